### rtl/core/rlrk_pkg.sv
// Shared types and constants for the reliable link reorder and keepalive unit.
`timescale 1ns / 1ps
package rlrk_pkg;
   localparam int WINDOW_SLOTS = 32;
   localparam int SLOT_BITS = $clog2(WINDOW_SLOTS);
   localparam int CSR_COUNT = 6;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_RECV = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] KIND_SENT = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_CLOSED = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATA_CMD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_CMD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEARTBEAT_CMD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GOODBYE_CMD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEARTBEAT_IDLE = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECV_TIMEOUT = 3'd5;

   typedef struct packed {
      logic [1:0] opcode;
      logic header_complete;
      logic [7:0] packet_command;
      logic [31:0] packet_sequence;
      logic [15:0] payload_tag;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] out_command;
      logic [31:0] out_sequence;
      logic [15:0] out_tag;
      logic last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data_cmd;
      logic [7:0] confirm_cmd;
      logic [7:0] heartbeat_cmd;
      logic [7:0] goodbye_cmd;
      logic [7:0] heartbeat_idle;
      logic [7:0] recv_timeout;
   } cfg_type;

   typedef enum logic [2:0] {
      CLS_SEND, CLS_REJECT, CLS_DATA, CLS_GOODBYE, CLS_OTHER, CLS_TICK
   } cls_type;

   typedef struct packed {
      logic valid;
      cls_type cls;
      logic [31:0] seq;
      logic [15:0] tag;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EMIT, ST_TICK, ST_SCAN, ST_CONFIRM, ST_DELIVER
   } state_type;
endpackage

### rtl/core/rlrk_front.sv
// Request queue and classification of incoming requests.
`timescale 1ns / 1ps
module rlrk_front import rlrk_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic req_push,
   input  req_type req_data,
   output logic req_full,
   output job_type job,
   input  logic job_take
);
   job_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   job_type cls_job;
   logic accept, drop;

   always_comb begin
      cls_job.valid = 1'b1;
      cls_job.seq = req_data.packet_sequence;
      cls_job.tag = req_data.payload_tag;
      drop = 1'b0;
      case (req_data.opcode)
         OP_SEND: cls_job.cls = CLS_SEND;
         OP_RECV: begin
            if (!req_data.header_complete) cls_job.cls = CLS_REJECT;
            else if (req_data.packet_command == cfg.data_cmd) cls_job.cls = CLS_DATA;
            else if (req_data.packet_command == cfg.goodbye_cmd) cls_job.cls = CLS_GOODBYE;
            else cls_job.cls = CLS_OTHER;
         end
         OP_TICK: cls_job.cls = CLS_TICK;
         default: begin
            cls_job.cls = CLS_OTHER;
            drop = 1'b1;
         end
      endcase
   end

   assign req_full = (count_ff == 2'd2);
   assign accept = req_push && !req_full;
   assign job = (count_ff != 2'd0) ? slot_ff[rd_ptr_ff] : '0;

   always_ff @(posedge clock) begin
      if (accept && !drop) slot_ff[wr_ptr_ff] <= cls_job;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (accept && !drop) wr_ptr_ff <= !wr_ptr_ff;
         if (job_take) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(accept && !drop) - 2'(job_take);
      end
   end
endmodule

### rtl/core/rlrk_back.sv
// Link engine: send numbering, receive window, confirm advance, keepalive timers.
`timescale 1ns / 1ps
module rlrk_back import rlrk_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  job_type job,
   output logic job_take,
   output logic emit_valid,
   output rsp_type emit_data,
   input  logic emit_room
);
   state_type state_ff, state_in;
   logic [31:0] next_ff, mark_ff, old_ff, pos_ff;
   logic [SLOT_BITS-1:0] steps_ff;
   logic any_ff, zero_ff, hb_ff, to_ff, watch_ff;
   logic [7:0] sidle_ff, ridle_ff;
   logic [WINDOW_SLOTS-1:0] valid_ff;
   logic [15:0] tag_ff [WINDOW_SLOTS];
   rsp_type res_ff, res_in;

   logic fire, adv, got_zero, in_win;
   logic [31:0] pos_next, gap;
   logic [SLOT_BITS-1:0] probe, pos_slot;
   logic [7:0] s_inc, r_inc;

   assign job_take = (state_ff == ST_IDLE) && job.valid;
   assign fire = emit_valid && emit_room;
   assign probe = mark_ff[SLOT_BITS-1:0] + SLOT_BITS'(1);
   assign adv = (steps_ff != SLOT_BITS'(WINDOW_SLOTS - 1)) && (mark_ff != '1) && valid_ff[probe];
   assign pos_next = pos_ff + 32'd1;
   assign pos_slot = pos_next[SLOT_BITS-1:0];
   assign gap = job.seq - mark_ff;
   assign got_zero = (mark_ff == '0) && (job.seq == '0);
   assign in_win = (job.seq > mark_ff) && (gap < 32'(WINDOW_SLOTS));
   assign s_inc = (sidle_ff == 8'hFF) ? sidle_ff : sidle_ff + 8'd1;
   assign r_inc = (ridle_ff == 8'hFF) ? ridle_ff : ridle_ff + 8'd1;

   always_comb begin
      res_in = '0;
      res_in.last_of_run = 1'b1;
      case (job.cls)
         CLS_SEND: begin
            res_in.result_kind = KIND_SENT;
            res_in.out_command = cfg.data_cmd;
            res_in.out_sequence = next_ff;
            res_in.out_tag = job.tag;
         end
         CLS_REJECT: res_in.result_kind = KIND_REJECT;
         default: res_in.result_kind = KIND_CLOSED;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      emit_valid = 1'b0;
      emit_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_take) begin
               case (job.cls) inside
                  CLS_SEND, CLS_REJECT, CLS_GOODBYE: state_in = ST_EMIT;
                  CLS_DATA: state_in = ST_SCAN;
                  CLS_TICK: state_in = ST_TICK;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMIT: begin
            emit_valid = 1'b1;
            emit_data = res_ff;
            if (emit_room) state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (hb_ff) begin
               emit_valid = 1'b1;
               emit_data.result_kind = KIND_SENT;
               emit_data.out_command = cfg.heartbeat_cmd;
               emit_data.last_of_run = !to_ff;
               if (emit_room && !to_ff) state_in = ST_IDLE;
            end else if (to_ff) begin
               emit_valid = 1'b1;
               emit_data.result_kind = KIND_CLOSED;
               emit_data.last_of_run = 1'b1;
               if (emit_room) state_in = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!adv) state_in = any_ff ? ST_CONFIRM : ST_IDLE;
         end
         ST_CONFIRM: begin
            emit_valid = 1'b1;
            emit_data.result_kind = KIND_SENT;
            emit_data.out_command = cfg.confirm_cmd;
            emit_data.out_sequence = mark_ff;
            emit_data.last_of_run = !zero_ff && (mark_ff == old_ff);
            if (emit_room) state_in = emit_data.last_of_run ? ST_IDLE : ST_DELIVER;
         end
         ST_DELIVER: begin
            emit_valid = 1'b1;
            emit_data.result_kind = KIND_DELIVER;
            if (zero_ff) begin
               emit_data.out_tag = tag_ff[0];
               emit_data.last_of_run = (pos_ff == mark_ff);
            end else begin
               emit_data.out_sequence = pos_next;
               emit_data.out_tag = tag_ff[pos_slot];
               emit_data.last_of_run = (pos_next == mark_ff);
            end
            if (emit_room && emit_data.last_of_run) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (job_take && job.cls == CLS_DATA && (got_zero || in_win))
         tag_ff[job.seq[SLOT_BITS-1:0]] <= job.tag;
      if (job_take) begin
         res_ff <= res_in;
         old_ff <= mark_ff;
         pos_ff <= mark_ff;
         steps_ff <= '0;
         any_ff <= (|valid_ff) || got_zero || in_win;
      end
      if (state_ff == ST_SCAN && adv) steps_ff <= steps_ff + SLOT_BITS'(1);
      if (state_ff == ST_DELIVER && fire && !zero_ff) pos_ff <= pos_next;
      if (reset) begin
         next_ff <= '0;
         mark_ff <= '0;
         valid_ff <= '0;
         sidle_ff <= '0;
         ridle_ff <= '0;
         watch_ff <= 1'b0;
         hb_ff <= 1'b0;
         to_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         if (job_take) begin
            case (job.cls) inside
               CLS_SEND: begin
                  next_ff <= next_ff + 32'd1;
                  sidle_ff <= '0;
                  if (!watch_ff) begin
                     watch_ff <= 1'b1;
                     ridle_ff <= '0;
                  end
               end
               CLS_DATA, CLS_GOODBYE, CLS_OTHER: begin
                  watch_ff <= 1'b1;
                  ridle_ff <= '0;
                  if (job.cls == CLS_DATA) begin
                     zero_ff <= got_zero;
                     if (got_zero || in_win) valid_ff[job.seq[SLOT_BITS-1:0]] <= 1'b1;
                  end
               end
               CLS_TICK: begin
                  hb_ff <= (s_inc > cfg.heartbeat_idle);
                  sidle_ff <= (s_inc > cfg.heartbeat_idle) ? 8'd0 : s_inc;
                  to_ff <= watch_ff && (r_inc > cfg.recv_timeout);
                  if (watch_ff) begin
                     if (r_inc > cfg.recv_timeout) begin
                        watch_ff <= 1'b0;
                        ridle_ff <= '0;
                     end else begin
                        ridle_ff <= r_inc;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_TICK && fire) begin
            if (hb_ff) hb_ff <= 1'b0;
            else to_ff <= 1'b0;
         end
         if (state_ff == ST_SCAN && adv) mark_ff <= mark_ff + 32'd1;
         if (state_ff == ST_DELIVER && fire) begin
            if (zero_ff) begin
               zero_ff <= 1'b0;
               valid_ff[0] <= 1'b0;
            end else begin
               valid_ff[pos_slot] <= 1'b0;
            end
         end
      end
   end
endmodule

### rtl/core/rlrk_rsp_queue.sv
// Two-entry result queue towards the response side.
`timescale 1ns / 1ps
module rlrk_rsp_queue import rlrk_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   input  rsp_type wr_data,
   output logic wr_room,
   output logic rsp_empty,
   output rsp_type rsp_data,
   input  logic rsp_pop
);
   rsp_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic wr, rd;

   assign wr_room = (count_ff != 2'd2);
   assign wr = wr_valid && wr_room;
   assign rsp_empty = (count_ff == 2'd0);
   assign rd = rsp_pop && !rsp_empty;
   assign rsp_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr) slot_ff[wr_ptr_ff] <= wr_data;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (wr) wr_ptr_ff <= !wr_ptr_ff;
         if (rd) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(wr) - 2'(rd);
      end
   end
endmodule

### rtl/core/reliable_link_reorder_and_keepalive_unit.sv
// Top level of the reliable link reorder and keepalive unit.
//  channel   ports                               handshake
//  request   req_push, req_full, req_data        push && !full
//  response  rsp_empty, rsp_pop, rsp_data        pop && !empty
//  csr       csr_write_enable, csr_index, csr_wdata  write_enable
// A data header first walks the confirm window, one step per cycle and at most
// WINDOW_SLOTS-1 steps, then writes its results into the result queue, one per cycle
// while the queue has room.
// Reset is synchronous and empties both queues; a full result queue stalls the engine
// while the request queue keeps taking requests until it fills.
`timescale 1ns / 1ps
module reliable_link_reorder_and_keepalive_unit import rlrk_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  req_type req_data,
   output logic req_full,
   output logic rsp_empty,
   output rsp_type rsp_data,
   input  logic rsp_pop,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   cfg_type cfg_ff;
   job_type job;
   logic job_take, emit_valid, emit_room;
   rsp_type emit_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_cmd <= 8'd0;
         cfg_ff.confirm_cmd <= 8'd1;
         cfg_ff.heartbeat_cmd <= 8'd2;
         cfg_ff.goodbye_cmd <= 8'd3;
         cfg_ff.heartbeat_idle <= 8'd10;
         cfg_ff.recv_timeout <= 8'd30;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DATA_CMD: cfg_ff.data_cmd <= csr_wdata;
            CSR_CONFIRM_CMD: cfg_ff.confirm_cmd <= csr_wdata;
            CSR_HEARTBEAT_CMD: cfg_ff.heartbeat_cmd <= csr_wdata;
            CSR_GOODBYE_CMD: cfg_ff.goodbye_cmd <= csr_wdata;
            CSR_HEARTBEAT_IDLE: cfg_ff.heartbeat_idle <= csr_wdata;
            CSR_RECV_TIMEOUT: cfg_ff.recv_timeout <= csr_wdata;
            default: ;
         endcase
      end
   end

   rlrk_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .job(job), .job_take(job_take)
   );

   rlrk_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .job(job), .job_take(job_take),
      .emit_valid(emit_valid), .emit_data(emit_data), .emit_room(emit_room)
   );

   rlrk_rsp_queue u_rsp_queue (
      .clock(clock), .reset(reset),
      .wr_valid(emit_valid), .wr_data(emit_data), .wr_room(emit_room),
      .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );
endmodule

### rtl/core/rlrk_checker.sv
// Port-level checks for the reliable link reorder and keepalive unit.
`timescale 1ns / 1ps
module rlrk_checker import rlrk_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_full,
   input  logic rsp_empty,
   input  rsp_type rsp_data,
   input  logic rsp_pop
);
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("results after reset");
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request queue full after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");
endmodule

bind reliable_link_reorder_and_keepalive_unit rlrk_checker u_rlrk_checker (
   .clock(clock), .reset(reset), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
);
